[src/stepper_ramp_pulse_generator_macros.svh]
// Assertion helpers for the checker file.
`ifndef STEPPER_RAMP_PULSE_GENERATOR_MACROS_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define SRPG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define SRPG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/srpg_pkg.sv]
package srpg_pkg;

  // Default widths.
  localparam int unsigned DelayBitsDefault    = 20;
  localparam int unsigned StepBitsDefault     = 32;
  localparam int unsigned IntervalBitsDefault = 16;

  // Register reset values.
  localparam int unsigned RunDelayReset      = 1000;
  localparam int unsigned StartDelayReset    = 0;
  localparam int unsigned FloorDelayReset    = 100;
  localparam int unsigned IntervalCountReset = 1;
  localparam int unsigned IntervalPauseReset = 0;

  // Command carried in the input tuser; the unused code behaves as a tick.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } opcode_e;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    CFG_RUN_DELAY      = 3'd0,
    CFG_START_DELAY    = 3'd1,
    CFG_FLOOR_DELAY    = 3'd2,
    CFG_INTERVAL_COUNT = 3'd3,
    CFG_INTERVAL_PAUSE = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_RUN   = 3'b010,
    PH_PAUSE = 3'b100
  } phase_e;

  // Single-bit status of one result.
  typedef struct packed {
    logic error;
    logic busy;
    logic enable;
    logic dir;
    logic step;
  } flags_t;

endpackage

[src/srpg_ctrl.sv]
module srpg_ctrl #(
  parameter int unsigned DELAY_BITS    = srpg_pkg::DelayBitsDefault,
  parameter int unsigned STEP_BITS     = srpg_pkg::StepBitsDefault,
  parameter int unsigned INTERVAL_BITS = srpg_pkg::IntervalBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_en_i,
  input  srpg_pkg::opcode_e        op_i,
  input  logic [STEP_BITS-1:0]     steps_i,
  input  logic                     dir_i,
  input  logic [DELAY_BITS-1:0]    run_delay_i,
  input  logic [DELAY_BITS-1:0]    start_delay_i,
  input  logic [DELAY_BITS-1:0]    floor_delay_i,
  input  logic [INTERVAL_BITS-1:0] interval_count_i,
  input  logic [DELAY_BITS-1:0]    interval_pause_i,
  output srpg_pkg::flags_t         flags_o,
  output logic [INTERVAL_BITS-1:0] interval_o,
  output logic [STEP_BITS-1:0]     steps_left_o
);

  localparam int unsigned CmpW = (DELAY_BITS > STEP_BITS) ? DELAY_BITS : STEP_BITS;

  srpg_pkg::phase_e         phase_q, phase_d;
  logic [DELAY_BITS-1:0]    tick_q, tick_d;
  logic [DELAY_BITS-1:0]    cur_q, cur_d;
  logic [DELAY_BITS-1:0]    lo_q, lo_d;
  logic [DELAY_BITS-1:0]    hi_q, hi_d;
  logic [STEP_BITS-1:0]     rem_q, rem_d;
  logic [STEP_BITS-1:0]     latched_q, latched_d;
  logic                     pulse_q, pulse_d;
  logic [INTERVAL_BITS-1:0] inum_q, inum_d;
  logic                     dir_q, dir_d;
  logic                     err_q, err_d;

  // Ramp bounds that a new interval starts from.
  logic [DELAY_BITS-1:0] ramp_lo, ramp_hi;
  assign ramp_lo = (run_delay_i > floor_delay_i) ? run_delay_i : floor_delay_i;
  assign ramp_hi = (start_delay_i > ramp_lo) ? start_delay_i : ramp_lo;

  logic [STEP_BITS-1:0]     rem_dec;
  logic [DELAY_BITS-1:0]    ramp_gap;
  logic [INTERVAL_BITS-1:0] inum_inc;
  logic                     tick_expired;
  assign rem_dec      = pulse_q ? (rem_q - STEP_BITS'(1)) : rem_q;
  assign ramp_gap     = hi_q - cur_q;
  assign inum_inc     = inum_q + INTERVAL_BITS'(1);
  assign tick_expired = (tick_q <= DELAY_BITS'(1));

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    cur_d     = cur_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    rem_d     = rem_q;
    latched_d = latched_q;
    pulse_d   = pulse_q;
    inum_d    = inum_q;
    dir_d     = dir_q;
    err_d     = err_q;
    case (op_i)
      srpg_pkg::OP_START: begin
        if (phase_q == srpg_pkg::PH_IDLE) begin
          if (run_delay_i == '0) begin
            err_d = 1'b1;
          end else begin
            err_d     = 1'b0;
            dir_d     = dir_i;
            latched_d = steps_i;
            pulse_d   = 1'b0;
            if ((steps_i == '0) || (interval_count_i == '0)) begin
              rem_d  = '0;
              inum_d = '0;
            end else begin
              inum_d  = INTERVAL_BITS'(1);
              lo_d    = ramp_lo;
              hi_d    = ramp_hi;
              cur_d   = ramp_hi;
              tick_d  = ramp_hi;
              rem_d   = steps_i;
              phase_d = srpg_pkg::PH_RUN;
            end
          end
        end
      end
      srpg_pkg::OP_STOP: begin
        phase_d = srpg_pkg::PH_IDLE;
        pulse_d = 1'b0;
        inum_d  = '0;
        tick_d  = '0;
      end
      default: begin
        case (phase_q)
          srpg_pkg::PH_RUN: begin
            if (tick_expired) begin
              pulse_d = ~pulse_q;
              rem_d   = rem_dec;
              if (rem_dec == '0) begin
                // Interval done: finish the run, pause, or go straight on.
                if (inum_q >= interval_count_i) begin
                  phase_d = srpg_pkg::PH_IDLE;
                  inum_d  = '0;
                end else if (interval_pause_i == '0) begin
                  inum_d  = inum_inc;
                  lo_d    = ramp_lo;
                  hi_d    = ramp_hi;
                  cur_d   = ramp_hi;
                  tick_d  = ramp_hi;
                  rem_d   = latched_q;
                  pulse_d = 1'b0;
                  phase_d = srpg_pkg::PH_RUN;
                end else begin
                  phase_d = srpg_pkg::PH_PAUSE;
                  tick_d  = interval_pause_i;
                end
              end else begin
                // Slow down once the steps left fit in the ramp, else speed up.
                if (CmpW'(ramp_gap) >= CmpW'(rem_dec)) begin
                  cur_d = cur_q + DELAY_BITS'(1);
                end else if (cur_q > lo_q) begin
                  cur_d = cur_q - DELAY_BITS'(1);
                end
                tick_d = cur_d;
              end
            end else begin
              tick_d = tick_q - DELAY_BITS'(1);
            end
          end
          srpg_pkg::PH_PAUSE: begin
            if (tick_expired) begin
              inum_d  = inum_inc;
              lo_d    = ramp_lo;
              hi_d    = ramp_hi;
              cur_d   = ramp_hi;
              tick_d  = ramp_hi;
              rem_d   = latched_q;
              pulse_d = 1'b0;
              phase_d = srpg_pkg::PH_RUN;
            end else begin
              tick_d = tick_q - DELAY_BITS'(1);
            end
          end
          default: ;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= srpg_pkg::PH_IDLE;
      tick_q    <= '0;
      cur_q     <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      rem_q     <= '0;
      latched_q <= '0;
      pulse_q   <= 1'b0;
      inum_q    <= '0;
      dir_q     <= 1'b0;
      err_q     <= 1'b0;
    end else if (item_en_i) begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      cur_q     <= cur_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      rem_q     <= rem_d;
      latched_q <= latched_d;
      pulse_q   <= pulse_d;
      inum_q    <= inum_d;
      dir_q     <= dir_d;
      err_q     <= err_d;
    end
  end

  // The result shows the state as it stands after the item.
  assign flags_o.step   = pulse_d;
  assign flags_o.dir    = dir_d;
  assign flags_o.enable = (phase_d == srpg_pkg::PH_RUN);
  assign flags_o.busy   = (phase_d != srpg_pkg::PH_IDLE);
  assign flags_o.error  = err_d;
  assign interval_o     = inum_d;
  assign steps_left_o   = rem_d;

endmodule

[src/stepper_ramp_pulse_generator.sv]
// Stepper ramp pulse generator with a trapezoidal speed profile.
// Every transfer on the slave stream is one timer tick and carries a command
// in s_axis_tuser_i: tick, start run or stop. A start transfer also brings the
// full steps per interval and the direction. Every input transfer yields
// exactly one result transfer on the master stream with the step, direction
// and enable levels for the driver plus busy, interval number, steps left and
// the start error flag, all as they stand after that tick.
// The state update and the result are computed from the stored state in the
// cycle of the input transfer, and the result is registered. Throughput is
// one transfer per cycle while s_axis_tready_o is high, set by the ramp and
// countdown update on the state registers.
// The result side holds two entries (output register and skid register), so
// s_axis_tready_o is registered and stays high while one result waits. It
// drops only when both entries are full, i.e. when a result is held back
// while another input transfer comes in, and rises again as soon as one
// is taken.
// Reset loads the configuration defaults, clears the control state and empties both
// result entries, leaving the motor idle and disabled. The user must send configuration
// writes through the write port only while no run is in progress; it is not enforced.
module stepper_ramp_pulse_generator #(
  parameter int unsigned DELAY_BITS    = srpg_pkg::DelayBitsDefault,
  parameter int unsigned STEP_BITS     = srpg_pkg::StepBitsDefault,
  parameter int unsigned INTERVAL_BITS = srpg_pkg::IntervalBitsDefault,
  localparam int unsigned CfgW      = (DELAY_BITS > INTERVAL_BITS) ? DELAY_BITS : INTERVAL_BITS,
  localparam int unsigned InTdataW  = ((STEP_BITS + 1 + 7) / 8) * 8,
  localparam int unsigned OutW      = 4 + INTERVAL_BITS + STEP_BITS + 1,
  localparam int unsigned OutTdataW = ((OutW + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_wdata_i,
  // Input stream.
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // Fields from bit 0: steps_per_interval, direction, zero padding.
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  // Fields from bit 0: opcode.
  input  logic [1:0]           s_axis_tuser_i,
  // Result stream.
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // Fields from bit 0: step_pin, dir_pin, motor_enable, busy_res,
  // interval_index, steps_left, start_error, zero padding.
  output logic [OutTdataW-1:0] m_axis_tdata_o
);

  // Configuration registers.
  logic [DELAY_BITS-1:0]    run_delay_q, start_delay_q, floor_delay_q, pause_q;
  logic [INTERVAL_BITS-1:0] icount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_delay_q   <= DELAY_BITS'(srpg_pkg::RunDelayReset);
      start_delay_q <= DELAY_BITS'(srpg_pkg::StartDelayReset);
      floor_delay_q <= DELAY_BITS'(srpg_pkg::FloorDelayReset);
      icount_q      <= INTERVAL_BITS'(srpg_pkg::IntervalCountReset);
      pause_q       <= DELAY_BITS'(srpg_pkg::IntervalPauseReset);
    end else if (cfg_we_i) begin
      case (srpg_pkg::cfg_idx_e'(cfg_idx_i))
        srpg_pkg::CFG_RUN_DELAY:      run_delay_q   <= cfg_wdata_i[DELAY_BITS-1:0];
        srpg_pkg::CFG_START_DELAY:    start_delay_q <= cfg_wdata_i[DELAY_BITS-1:0];
        srpg_pkg::CFG_FLOOR_DELAY:    floor_delay_q <= cfg_wdata_i[DELAY_BITS-1:0];
        srpg_pkg::CFG_INTERVAL_COUNT: icount_q      <= cfg_wdata_i[INTERVAL_BITS-1:0];
        srpg_pkg::CFG_INTERVAL_PAUSE: pause_q       <= cfg_wdata_i[DELAY_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic in_xfer;
  assign in_xfer = s_axis_tvalid_i & s_axis_tready_o;

  srpg_pkg::flags_t         flags;
  logic [INTERVAL_BITS-1:0] interval_idx;
  logic [STEP_BITS-1:0]     steps_left;

  srpg_ctrl #(
    .DELAY_BITS    (DELAY_BITS),
    .STEP_BITS     (STEP_BITS),
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_en_i        (in_xfer),
    .op_i             (srpg_pkg::opcode_e'(s_axis_tuser_i)),
    .steps_i          (s_axis_tdata_i[STEP_BITS-1:0]),
    .dir_i            (s_axis_tdata_i[STEP_BITS]),
    .run_delay_i      (run_delay_q),
    .start_delay_i    (start_delay_q),
    .floor_delay_i    (floor_delay_q),
    .interval_count_i (icount_q),
    .interval_pause_i (pause_q),
    .flags_o          (flags),
    .interval_o       (interval_idx),
    .steps_left_o     (steps_left)
  );

  logic [OutW-1:0] result;
  assign result = {flags.error, steps_left, interval_idx,
                   flags.busy, flags.enable, flags.dir, flags.step};

  // Two-entry result buffer: output register plus skid register.
  logic            out_valid_q, out_valid_d;
  logic            skid_valid_q, skid_valid_d;
  logic [OutW-1:0] out_data_q, skid_data_q;
  logic            out_xfer, load_out, load_skid, move_skid;

  assign out_xfer = out_valid_q & m_axis_tready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    load_out     = 1'b0;
    load_skid    = 1'b0;
    move_skid    = 1'b0;
    if (out_xfer) begin
      if (skid_valid_q) begin
        move_skid    = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (in_xfer) begin
      if (!out_valid_q || (out_xfer && !skid_valid_q)) begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= result;
    end else if (move_skid) begin
      out_data_q <= skid_data_q;
    end
    if (load_skid) begin
      skid_data_q <= result;
    end
  end

  assign s_axis_tready_o = ~skid_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutTdataW'(out_data_q);

endmodule

[src/srpg_checker.sv]
`include "stepper_ramp_pulse_generator_macros.svh"

module srpg_checker #(
  parameter int unsigned OutTdataW = 56
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [OutTdataW-1:0] m_axis_tdata_o
);

  // Every input transfer leaves a result pending in the next cycle.
  `SRPG_ASSERT_NXT(a_result_follows, s_axis_tvalid_i && s_axis_tready_o, m_axis_tvalid_o, "input transfer without a result")

  // The input side stalls only while a result is held back.
  `SRPG_ASSERT_IMP(a_stall_needs_backlog, !s_axis_tready_o, m_axis_tvalid_o, "input stalled with no pending result")

  // A stalled result stays offered.
  `SRPG_ASSERT_NXT(a_valid_holds, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o, "result withdrawn while stalled")

  // A stalled result keeps its payload.
  `SRPG_ASSERT_NXT(a_data_holds, m_axis_tvalid_o && !m_axis_tready_i, $stable(m_axis_tdata_o), "result changed while stalled")

endmodule

bind stepper_ramp_pulse_generator srpg_checker #(
  .OutTdataW (OutTdataW)
) u_srpg_checker (.*);
